/* rtl/si2dec_pkg.sv */
package si2dec_pkg;

    localparam int MAG_W  = 64;
    localparam int DIGITS = 20;
    localparam int BCD_W  = 4 * DIGITS;
    localparam int CHAR_W = 6;
    localparam int CNT_W  = $clog2(MAG_W);
    localparam int REM_W  = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } item_t;

endpackage

/* rtl/si2dec_front.sv */
module si2dec_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // value[63:0]
    output logic                  q_valid,
    input  logic                  q_ready,
    output si2dec_pkg::item_t     q_data
);
    import si2dec_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg, item_next;
    logic  s_acc, push;

    assign push     = valid_reg && q_ready;
    assign s_tready = !valid_reg || q_ready;
    assign s_acc    = s_tvalid && s_tready;
    assign q_valid  = valid_reg;
    assign q_data   = item_reg;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (push) begin
            valid_next = 1'b0;
        end
        if (s_acc) begin
            valid_next    = 1'b1;
            item_next.neg = s_tdata[MAG_W-1];
            item_next.mag = s_tdata[MAG_W-1] ? (~s_tdata + 64'd1) : s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        item_reg <= item_next;
    end

endmodule

/* rtl/si2dec_fifo.sv */
module si2dec_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  si2dec_pkg::item_t     in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output si2dec_pkg::item_t     out_data
);
    import si2dec_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W2 = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W2-1:0] CNT_FULL = CNT_W2'(DEPTH);

    item_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CNT_W2-1:0]  cnt_reg, cnt_next;
    logic               push, pop;

    assign in_ready  = (cnt_reg != CNT_FULL);
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= in_data;
        end
    end

endmodule

/* rtl/si2dec_back.sv */
module si2dec_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  si2dec_pkg::item_t     q_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // character[5:0], zero pad[7:6]
    output logic                  m_tlast
);
    import si2dec_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_SKIP,
        ST_EMIT
    } state_t;

    localparam logic [CNT_W-1:0] CNT_LAST   = CNT_W'(MAG_W - 1);
    localparam logic [REM_W-1:0] REM_FULL   = REM_W'(DIGITS);
    localparam logic [REM_W-1:0] REM_ONE    = REM_W'(1);

    function automatic logic [BCD_W-1:0] add3(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        r = b;
        for (int i = 0; i < DIGITS; i++) begin
            if (b[4*i +: 4] > 4'd4) begin
                r[4*i +: 4] = b[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    state_t             state_reg, state_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   bcd_adj;
    logic [MAG_W-1:0]   sh_reg, sh_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic               neg_reg, neg_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]  m_char_reg, m_char_next;
    logic               m_tlast_reg, m_tlast_next;
    logic               out_free;
    logic [3:0]         top_digit;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign top_digit = bcd_reg[BCD_W-1 -: 4];
    assign bcd_adj   = add3(bcd_reg);
    assign q_ready   = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {2'b00, m_char_reg};
    assign m_tlast   = m_tlast_reg;

    always_comb begin
        state_next    = state_reg;
        bcd_next      = bcd_reg;
        sh_next       = sh_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        neg_next      = neg_reg;
        m_char_next   = m_char_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    sh_next    = q_data.mag;
                    neg_next   = q_data.neg;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                {bcd_next, sh_next} = {bcd_adj[BCD_W-2:0], sh_reg, 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    rem_next   = REM_FULL;
                    state_next = neg_reg ? ST_SIGN : ST_SKIP;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = ASCII_MINUS;
                    m_tlast_next  = 1'b0;
                    state_next    = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (top_digit == 4'd0 && rem_reg != REM_ONE) begin
                    bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
                    rem_next = rem_reg - 1'b1;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_char_next   = ASCII_ZERO + {2'b00, top_digit};
                    m_tlast_next  = (rem_reg == REM_ONE);
                    bcd_next      = {bcd_reg[BCD_W-5:0], 4'd0};
                    rem_next      = rem_reg - 1'b1;
                    if (rem_reg == REM_ONE) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        bcd_reg     <= bcd_next;
        sh_reg      <= sh_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        neg_reg     <= neg_next;
        m_char_reg  <= m_char_next;
        m_tlast_reg <= m_tlast_next;
    end

    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_char_reg == ASCII_MINUS ||
                          (m_char_reg >= ASCII_ZERO && m_char_reg <= ASCII_NINE)))
        else $error("result character outside the sign and digit codes");

    a_sign_only_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SIGN) |-> neg_reg)
        else $error("sign state entered for a non-negative value");

    a_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SKIP || state_reg == ST_EMIT) |-> (rem_reg != '0))
        else $error("digit count exhausted before the last character");

    a_bcd_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SKIP || state_reg == ST_EMIT) |-> (top_digit <= 4'd9))
        else $error("leading BCD digit is not a decimal digit");

    a_last_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && rem_reg == REM_ONE)
            |=> (state_reg == ST_IDLE && m_tvalid_reg && m_tlast_reg))
        else $error("final character not flagged or sequencer not back in idle");

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// An accepted value passes the input register and the queue, then the converter's
// 64 shift-and-adjust steps, before its sign (if negative) and its digits leave;
// each suppressed leading zero takes a skip step of its own before the first digit.
// The bit-serial BCD converter takes a new value only from idle, once its last character
// is registered; its digits leave at one per cycle while m_tready is high.
// Reset (aresetn low, synchronous) empties the input register, the queue and the converter.
module signed_int_to_decimal_ascii #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value[63:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // character[5:0], zero pad[7:6]
    output logic        m_tlast
);
    import si2dec_pkg::*;

    item_t f_data, b_data;
    logic  f_valid, f_ready, b_valid, b_ready;

    si2dec_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_data   (f_data)
    );

    si2dec_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    si2dec_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (b_valid),
        .q_ready  (b_ready),
        .q_data   (b_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* test/decimal_text_checker.sv */
module decimal_text_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // value[63:0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // character[5:0], zero pad[7:6]
    input  logic        m_tlast,
    output logic [31:0] mismatches,
    output logic [31:0] outstanding
);
    import si2dec_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    text_char_t expected_text[$];

    // Digits are produced least significant first and then queued in reading order.
    function automatic void push_decimal_text(input logic [63:0] value);
        logic [MAG_W-1:0]  mag;
        logic [CHAR_W-1:0] rev [DIGITS];
        int                n;
        text_char_t        tc;
        mag = value[63] ? (~value + 64'd1) : value;
        n = 0;
        do begin
            rev[n] = ASCII_ZERO + CHAR_W'(mag % 64'd10);
            n++;
            mag = mag / 64'd10;
        end while (mag != 0 && n < DIGITS);
        if (value[63] && n < DIGITS) begin
            rev[n] = ASCII_MINUS;
            n++;
        end
        for (int k = n - 1; k >= 0; k--) begin
            tc.code = rev[k];
            tc.last = (k == 0);
            expected_text.push_back(tc);
        end
    endfunction

    always @(posedge aclk) begin
        text_char_t want;
        if (!aresetn) begin
            mismatches = '0;
            expected_text.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_text.size() == 0) begin
                    mismatches = mismatches + 32'd1;
                    $error("character: expected none, got %0d", m_tdata[CHAR_W-1:0]);
                end else begin
                    want = expected_text.pop_front();
                    if (m_tdata[CHAR_W-1:0] !== want.code) begin
                        mismatches = mismatches + 32'd1;
                        $error("character: expected %0d, got %0d",
                               want.code, m_tdata[CHAR_W-1:0]);
                    end
                    if (m_tlast !== want.last) begin
                        mismatches = mismatches + 32'd1;
                        $error("last: expected %0b, got %0b", want.last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                push_decimal_text(s_tdata);
            end
        end
        outstanding = 32'(expected_text.size());
    end

endmodule

/* test/tb.sv */
module tb;

    localparam int RANDOM_VALUES   = 390;
    localparam int HOLD_OFF_ITEM   = 150;
    localparam int HOLD_OFF_CYCLES = 2000;
    localparam int TAIL_CYCLES     = 200;
    localparam int LIMIT           = 1500000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = 64'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    logic [31:0] mismatches;
    logic [31:0] outstanding;

    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;
    int values_sent   = 0;
    int negatives     = 0;
    int cycle_count   = 0;

    signed_int_to_decimal_ascii u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    decimal_text_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("signed_int_to_decimal_ascii regression: fail");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (hold_off_req && !hold_off_done) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] mag;
        logic [63:0] pow;
        int          digits;
        int          mode;
        mode = $urandom_range(0, 9);
        if (mode < 4) begin
            return {$urandom, $urandom};
        end
        if (mode < 6) begin
            mag = 64'($urandom_range(0, 1000));
        end else begin
            digits = $urandom_range(1, 19);
            pow = 64'd1;
            for (int i = 0; i < digits; i++) pow = pow * 64'd10;
            mag = {$urandom, $urandom} % pow;
        end
        return $urandom_range(0, 1) ? (~mag + 64'd1) : mag;
    endfunction

    task automatic send_value(input logic [63:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        values_sent++;
        if (value[63]) negatives++;
    endtask

    // Output side: random runs of ready and not ready, plus one long hold-off on request.
    initial begin
        int r;
        int len;
        @(posedge aclk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                m_tready <= 1'b0;
                for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(posedge aclk);
                hold_off_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 60) begin
                    m_tready <= 1'b1;
                    len = $urandom_range(1, 30);
                end else if (r < 68) begin
                    m_tready <= 1'b1;
                    len = $urandom_range(50, 200);
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                    len = $urandom_range(1, 4);
                end else begin
                    m_tready <= 1'b0;
                    len = $urandom_range(10, 30);
                end
                repeat (len) @(posedge aclk);
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_value(64'd0);
        send_value(64'd1);
        send_value(-64'd1);
        send_value(64'd9);
        send_value(-64'd9);
        send_value(64'd10);
        send_value(-64'd10);
        send_value(64'd99);
        send_value(64'd100);
        send_value(-64'd100);
        send_value(64'd999999999999999999);
        send_value(64'd1000000000000000000);
        send_value(-64'd1000000000000000000);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_value(64'h8000_0000_0000_0000);
        send_value(64'h8000_0000_0000_0001);
        send_value(64'd1234567890123456789);
        send_value(-64'd1234567890123456789);
        send_value(64'h5555_5555_5555_5555);
        send_value(64'hAAAA_AAAA_AAAA_AAAA);

        for (int i = 0; i < RANDOM_VALUES; i++) begin
            if (i == HOLD_OFF_ITEM) hold_off_req = 1'b1;
            send_value(random_value());
        end
        s_tvalid <= 1'b0;

        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        @(negedge aclk);

        $display("Converted %0d values, %0d of them negative, including zero and both extremes.",
                 values_sent, negatives);
        $display("Both sides idled at random and the output held off once for %0d cycles.",
                 HOLD_OFF_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("signed_int_to_decimal_ascii regression: pass");
        end else begin
            $display("signed_int_to_decimal_ascii regression: fail");
        end
        $finish;
    end

endmodule
